@@ sv/mwsf_pkg.sv @@
`default_nettype none

package mwsf_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int PAT_FIELD_W = 4;
  localparam int SLOT_FIELD_W = 4;
  localparam int LEN_FIELD_W = 5;

  localparam int NUM_PATTERNS_DEF = 16;
  localparam int PATTERN_LEN_DEF  = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_STREAM = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SETLEN = 2'd2;

  typedef enum logic [1:0] {
    CMD_STREAM = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_SETLEN = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic                     first;
    logic [DATA_W-1:0]        data;
    logic [DATA_W-1:0]        mask;
    logic [PAT_FIELD_W-1:0]   pattern;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [LEN_FIELD_W-1:0]   length;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/mwsf_if.sv @@
`default_nettype none

interface mwsf_cmd_if;
  import mwsf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic                    first;
  logic [DATA_W-1:0]       data;
  logic [DATA_W-1:0]       mask;
  logic [PAT_FIELD_W-1:0]  pattern;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [LEN_FIELD_W-1:0]  length;

  modport source (output valid, op, first, data, mask, pattern, slot, length,
                  input ready);
  modport sink (input valid, op, first, data, mask, pattern, slot, length,
                output ready);
endinterface

interface mwsf_hit_if;
  import mwsf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PAT_FIELD_W-1:0] pattern_hit;
  logic [DATA_W-1:0]      start_position;
  logic                   last;

  modport source (output valid, pattern_hit, start_position, last, input ready);
  modport sink (input valid, pattern_hit, start_position, last, output ready);
endinterface

`default_nettype wire

@@ sv/masked_word_sequence_finder.sv @@
`default_nettype none

// Masked multi-pattern word search. Requests on cmd either load one masked
// word of a pattern, set a pattern's length (0 disables it) or stream one
// data word; a stream word with first set starts a new buffer. For every
// stream word the block reports, on hit, each pattern whose words match the
// tail of the current buffer, in ascending pattern order, with the buffer
// offset of the match's first word; last marks the final report for a word.
// Requests are taken into a four-entry queue at one per cycle while it has
// room. The execution engine takes one request at a time from the queue and
// takes no other until it is through: a load or length request is applied
// as it is taken, while a stream word is compared against the pattern table,
// which is read one pattern row per cycle, and its matches are then walked
// and reported in ascending pattern order, waiting while hit is stalled.
// Pattern words must be loaded before a pattern that uses them is enabled.
module masked_word_sequence_finder #(
  parameter int NUM_PATTERNS = mwsf_pkg::NUM_PATTERNS_DEF,
  parameter int PATTERN_LEN  = mwsf_pkg::PATTERN_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mwsf_cmd_if.sink    cmd,
  mwsf_hit_if.source  hit
);
  import mwsf_pkg::*;

  cmd_t q_push_entry;
  cmd_t q_pop_entry;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  mwsf_front #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .PATTERN_LEN (PATTERN_LEN)
  ) u_front (
    .cmd  (cmd),
    .full (q_full),
    .push (q_push),
    .entry(q_push_entry)
  );

  mwsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_entry (q_pop_entry),
    .valid     (q_valid)
  );

  mwsf_back #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .PATTERN_LEN (PATTERN_LEN)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_entry(q_pop_entry),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .hit    (hit)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("request queued while the queue is full");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("engine took a request from an empty queue");

  a_entry_kept: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued request vanished without being taken");

endmodule

`default_nettype wire

@@ sv/mwsf_ram.sv @@
`default_nettype none

module mwsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mwsf_front.sv @@
`default_nettype none

module mwsf_front #(
  parameter int NUM_PATTERNS = 16,
  parameter int PATTERN_LEN  = 16
) (
  mwsf_cmd_if.sink        cmd,
  input  logic            full,
  output logic            push,
  output mwsf_pkg::cmd_t  entry
);
  import mwsf_pkg::*;

  logic pat_ok;
  logic slot_ok;
  logic keep;

  assign cmd.ready = !full;
  assign pat_ok    = 32'(cmd.pattern) < 32'(NUM_PATTERNS);
  assign slot_ok   = 32'(cmd.slot) < 32'(PATTERN_LEN);

  // Requests that would change nothing are dropped here and never queued.
  always_comb begin
    entry.kind    = CMD_STREAM;
    entry.first   = cmd.first;
    entry.data    = cmd.data;
    entry.mask    = cmd.mask;
    entry.pattern = cmd.pattern;
    entry.slot    = cmd.slot;
    entry.length  = cmd.length;
    keep          = 1'b0;
    unique case (cmd.op)
      OP_STREAM: begin
        keep = 1'b1;
      end
      OP_LOAD: begin
        entry.kind = CMD_LOAD;
        keep       = pat_ok && slot_ok;
      end
      OP_SETLEN: begin
        entry.kind = CMD_SETLEN;
        keep       = pat_ok;
        if (32'(cmd.length) > 32'(PATTERN_LEN)) begin
          entry.length = LEN_FIELD_W'(PATTERN_LEN);
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = cmd.valid && cmd.ready && keep;

endmodule

`default_nettype wire

@@ sv/mwsf_queue.sv @@
`default_nettype none

module mwsf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mwsf_pkg::cmd_t  push_entry,
  output logic            full,
  input  logic            pop,
  output mwsf_pkg::cmd_t  pop_entry,
  output logic            valid
);
  import mwsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign valid     = count != '0;
  assign pop_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ sv/mwsf_back.sv @@
`default_nettype none

module mwsf_back #(
  parameter int NUM_PATTERNS = 16,
  parameter int PATTERN_LEN  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  mwsf_pkg::cmd_t  q_entry,
  input  logic            q_valid,
  output logic            q_pop,
  mwsf_hit_if.source      hit
);
  import mwsf_pkg::*;

  localparam int PIDX_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int LEN_W   = $clog2(PATTERN_LEN + 1);
  localparam int CNT_W   = $clog2(NUM_PATTERNS + 1);
  localparam int HIST_D  = (PATTERN_LEN > 1) ? PATTERN_LEN - 1 : 1;
  localparam int WIN_W   = PATTERN_LEN * DATA_W;
  localparam int WORD_SH = $clog2(DATA_W);
  localparam int SH_W    = LEN_W + WORD_SH;
  localparam int ENTRY_W = 2 * DATA_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  len_tab [NUM_PATTERNS];
  logic [DATA_W-1:0] hist [HIST_D];
  logic [LEN_W-1:0]  fill;
  logic [DATA_W-1:0] pos;
  logic [DATA_W-1:0] here;
  logic [DATA_W-1:0] cur_word;
  logic [CNT_W-1:0]  scan_p;
  logic [CNT_W-1:0]  hit_cnt;
  logic [PIDX_W-1:0] emit_p;
  logic [PIDX_W-1:0] cmp_p;
  logic [NUM_PATTERNS-1:0] hits;
  logic              cmp_valid;
  logic              cmp_ok;
  logic [PATTERN_LEN-1:0] cmp_use;
  logic [DATA_W-1:0] cmp_win [PATTERN_LEN];

  logic                    out_valid;
  logic [PAT_FIELD_W-1:0]  out_pattern;
  logic [DATA_W-1:0]       out_start;
  logic                    out_last;

  logic [PATTERN_LEN-1:0] ram_we;
  logic [PIDX_W-1:0]      ram_waddr;
  logic [PIDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata [PATTERN_LEN];

  logic                   issue;
  logic [PIDX_W-1:0]      len_addr;
  logic [LEN_W-1:0]       len_rd;
  logic [LEN_W-1:0]       sh_words;
  logic [WIN_W-1:0]       rvec;
  logic [WIN_W-1:0]       aligned;
  logic [PATTERN_LEN-1:0] use_v;
  logic [PATTERN_LEN-1:0] ok_v;
  logic                   cmp_hit;
  logic                   cmp_last;
  logic                   out_free;
  logic                   emit_now;
  logic                   pop_stream;

  assign q_pop      = (state == S_IDLE) && q_valid;
  assign pop_stream = q_pop && (q_entry.kind == CMD_STREAM);

  // One RAM per pattern word slot, addressed by pattern, so that all words of
  // a pattern row are read together.
  assign ram_waddr = PIDX_W'(q_entry.pattern);
  assign ram_wdata = {q_entry.data, q_entry.mask};
  assign ram_raddr = scan_p[PIDX_W-1:0];

  for (genvar x = 0; x < PATTERN_LEN; x++) begin : g_slot
    assign ram_we[x] = q_pop && (q_entry.kind == CMD_LOAD) && (32'(q_entry.slot) == x);

    mwsf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_PATTERNS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[x]),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata[x])
    );

    // Window reversed so that slot x of a pattern of length L lines up
    // with word x + PATTERN_LEN - L of this vector.
    if (x == PATTERN_LEN - 1) begin : g_cur
      assign rvec[x*DATA_W +: DATA_W] = cur_word;
    end else begin : g_hist
      assign rvec[x*DATA_W +: DATA_W] = hist[PATTERN_LEN-2-x];
    end

    assign use_v[x] = LEN_W'(x) < len_rd;
    assign ok_v[x]  = !cmp_use[x] ||
                      ((cmp_win[x] & ram_rdata[x][DATA_W-1:0]) ==
                       ram_rdata[x][ENTRY_W-1:DATA_W]);
  end

  assign issue    = (state == S_SCAN) && (scan_p < CNT_W'(NUM_PATTERNS));
  assign len_addr = (state == S_EMIT) ? emit_p : scan_p[PIDX_W-1:0];
  assign len_rd   = len_tab[len_addr];
  assign sh_words = LEN_W'(PATTERN_LEN) - len_rd;
  assign aligned  = rvec >> SH_W'({sh_words, WORD_SH'(0)});
  assign cmp_hit  = cmp_valid && cmp_ok && (&ok_v);
  assign cmp_last = cmp_p == PIDX_W'(NUM_PATTERNS - 1);
  assign out_free = !out_valid || hit.ready;
  assign emit_now = (state == S_EMIT) && (hit_cnt != '0) && hits[emit_p] && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pos       <= '0;
      scan_p    <= '0;
      hit_cnt   <= '0;
      emit_p    <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        len_tab[p] <= '0;
      end
    end else begin
      cmp_valid <= issue;
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (hit.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_entry.kind)
              CMD_STREAM: begin
                if (q_entry.first) begin
                  fill <= '0;
                  pos  <= '0;
                end
                scan_p  <= '0;
                hit_cnt <= '0;
                state   <= S_SCAN;
              end
              CMD_SETLEN: begin
                len_tab[PIDX_W'(q_entry.pattern)] <= LEN_W'(q_entry.length);
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_p <= scan_p + CNT_W'(1);
          end
          if (cmp_hit) begin
            hit_cnt <= hit_cnt + CNT_W'(1);
          end
          if (cmp_valid && cmp_last) begin
            emit_p <= '0;
            state  <= S_EMIT;
            if (fill != LEN_W'(PATTERN_LEN - 1)) begin
              fill <= fill + LEN_W'(1);
            end
            if (pos != '1) begin
              pos <= pos + DATA_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (hit_cnt == '0) begin
            state <= S_IDLE;
          end else if (emit_now) begin
            hit_cnt <= hit_cnt - CNT_W'(1);
            emit_p  <= emit_p + PIDX_W'(1);
          end else if (!hits[emit_p]) begin
            emit_p <= emit_p + PIDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_stream) begin
      cur_word <= q_entry.data;
      here     <= q_entry.first ? '0 : pos;
      hits     <= '0;
    end
    if (issue) begin
      cmp_p   <= scan_p[PIDX_W-1:0];
      cmp_use <= use_v;
      cmp_ok  <= (len_rd != '0) && ((len_rd - LEN_W'(1)) <= fill);
      for (int x = 0; x < PATTERN_LEN; x++) begin
        cmp_win[x] <= aligned[x*DATA_W +: DATA_W];
      end
    end
    if (cmp_hit) begin
      hits[cmp_p] <= 1'b1;
    end
    // The word just scanned joins the history once its scan is over.
    if ((state == S_SCAN) && cmp_valid && cmp_last) begin
      hist[0] <= cur_word;
      for (int k = 1; k < HIST_D; k++) begin
        hist[k] <= hist[k-1];
      end
    end
    if (emit_now) begin
      out_pattern <= PAT_FIELD_W'(emit_p);
      out_start   <= here - (DATA_W'(len_rd) - DATA_W'(1));
      out_last    <= hit_cnt == CNT_W'(1);
    end
  end

  assign hit.valid          = out_valid;
  assign hit.pattern_hit    = out_pattern;
  assign hit.start_position = out_start;
  assign hit.last           = out_last;

endmodule

`default_nettype wire
